// File: hdl/mrg3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_pkg
// Shared constants and types of the third-order recursive uniform generator.
// ----------------------------------------------------------------------------
package mrg3_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IndexWidth = 2;

   // Modulus 2^32 - 5 and the reset value of seeds and history.
   localparam logic [WordWidth-1:0] MrgPrime  = 32'd4294967291;
   localparam logic [WordWidth-1:0] SeedReset = 32'd10;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [IndexWidth-1:0] {
      CSR_SEED_NEWEST = 2'd0,
      CSR_SEED_MIDDLE = 2'd1,
      CSR_SEED_OLDEST = 2'd2
   } csr_index_type;

   typedef struct packed {
      word_type newest;
      word_type middle;
      word_type oldest;
   } seed_type;

   // Control from the handshake logic to the history datapath.
   typedef struct packed {
      logic advance;
      logic reload;
   } ctl_type;

endpackage
`default_nettype wire

// File: hdl/mrg3_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_req_if
// Request channel: one item either draws a value or reloads the history.
// ----------------------------------------------------------------------------
interface mrg3_req_if;
   logic valid;
   logic ready;
   logic reload;

   modport source (output valid, output reload, input ready);
   modport sink (input valid, input reload, output ready);
endinterface
`default_nettype wire

// File: hdl/mrg3_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_rsp_if
// Response channel: one item carries one generator value.
// ----------------------------------------------------------------------------
interface mrg3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: hdl/mrg3_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_csr
// Seed register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mrg3_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [mrg3_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [mrg3_pkg::WordWidth-1:0]  csr_wdata,
   output mrg3_pkg::seed_type              seeds
);
   import mrg3_pkg::*;

   seed_type seeds_ff;
   seed_type seeds_in;

   always_comb begin
      seeds_in = seeds_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SEED_NEWEST: seeds_in.newest = csr_wdata;
            CSR_SEED_MIDDLE: seeds_in.middle = csr_wdata;
            CSR_SEED_OLDEST: seeds_in.oldest = csr_wdata;
            default: seeds_in = seeds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff <= '{newest: SeedReset, middle: SeedReset, oldest: SeedReset};
      end else begin
         seeds_ff <= seeds_in;
      end
   end

   assign seeds = seeds_ff;

endmodule
`default_nettype wire

// File: hdl/mrg3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_core
// History registers and the weighted-sum step reduced modulo 2^32 - 5.
// ----------------------------------------------------------------------------
module mrg3_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mrg3_pkg::ctl_type           ctl,
   input  wire mrg3_pkg::seed_type          seeds,
   output logic [mrg3_pkg::WordWidth-1:0]   next_value
);
   import mrg3_pkg::*;

   seed_type hist_ff;
   seed_type hist_in;

   logic [44:0] acc;
   logic [32:0] fold_one;
   logic [32:0] fold_two;
   word_type    folded;

   // Constant multiplies; the sum stays below 2^45.
   always_comb begin
      acc = 45'(hist_ff.newest) * 45'd1176
          + 45'(hist_ff.middle) * 45'd1476
          + 45'(hist_ff.oldest) * 45'd1776;
   end

   // 2^32 is congruent to 5, so the upper bits fold back in times five. After
   // two folds the value is below 2^32 and one conditional subtract finishes.
   always_comb begin
      fold_one = {1'b0, acc[31:0]} + 33'(acc[44:32]) * 33'd5;
      fold_two = {1'b0, fold_one[31:0]} + (fold_one[32] ? 33'd5 : 33'd0);
      folded   = fold_two[31:0];
      if (folded >= MrgPrime) begin
         next_value = folded - MrgPrime;
      end else begin
         next_value = folded;
      end
   end

   always_comb begin
      hist_in = hist_ff;
      if (ctl.advance) begin
         if (ctl.reload) begin
            hist_in = seeds;
         end else begin
            hist_in.oldest = hist_ff.middle;
            hist_in.middle = hist_ff.newest;
            hist_in.newest = next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{newest: SeedReset, middle: SeedReset, oldest: SeedReset};
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/mrg3_uniform_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrg3_uniform_generator
// Third-order multiple recursive generator over 2^32 - 5, one value per draw.
// ----------------------------------------------------------------------------
// Path: a draw accepted on req_chan is loaded into the input register, then the
// history step runs into the result register once that register is free, and
// the value waits there on rsp_chan until it is taken.
// Throughput: one item per cycle unless a draw meets a held result register; the
// history step is one stage and a reload item passes by the result register.
// Reset: synchronous; seeds and history return to 10 and both stages empty.
module mrg3_uniform_generator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mrg3_req_if.sink                             req_chan,
   mrg3_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [mrg3_pkg::IndexWidth-1:0] csr_index,
   input  wire logic [mrg3_pkg::WordWidth-1:0]  csr_wdata
);
   import mrg3_pkg::*;

   seed_type seeds;
   ctl_type  core_ctl;
   word_type next_value;

   logic     in_valid_ff;
   logic     in_valid_in;
   logic     in_reload_ff;
   logic     in_reload_in;
   logic     out_valid_ff;
   logic     out_valid_in;
   word_type out_sample_ff;
   word_type out_sample_in;

   logic     slot_free;
   logic     req_take;
   logic     draw_done;

   mrg3_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .seeds     (seeds)
   );

   mrg3_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (core_ctl),
      .seeds      (seeds),
      .next_value (next_value)
   );

   // A reload item never needs the result register, so it always moves on.
   assign slot_free        = !out_valid_ff || rsp_chan.ready;
   assign core_ctl.reload  = in_reload_ff;
   assign core_ctl.advance = in_valid_ff && (in_reload_ff || slot_free);
   assign draw_done        = core_ctl.advance && !in_reload_ff;

   assign req_chan.ready = !in_valid_ff || core_ctl.advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_reload_in = in_reload_ff;
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_reload_in = req_chan.reload;
      end else if (core_ctl.advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (draw_done) begin
         out_valid_in  = 1'b1;
         out_sample_in = next_value;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_reload_ff  <= in_reload_in;
      out_sample_ff <= out_sample_in;
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.sample = out_sample_ff;

   // A pending draw must wait while the result register is held.
   a_draw_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_reload_ff && out_valid_ff && !rsp_chan.ready |=> in_valid_ff)
      else $error("pending draw item lost while the result was stalled");

   // A new result only appears after a draw went through the history step.
   a_result_from_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(draw_done))
      else $error("result item appeared without a draw");

   // Every value leaving the block is fully reduced.
   a_sample_reduced: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_sample_ff < MrgPrime)
      else $error("result item not reduced modulo the prime");

   // A reload item never occupies the result register.
   a_reload_silent: assert property (@(posedge clock) disable iff (reset)
      core_ctl.advance && in_reload_ff && !out_valid_ff |=> !out_valid_ff)
      else $error("reload item produced a result");

endmodule
`default_nettype wire
